### hdl/etm_pkg.sv
// Shared constants and elaboration-time table functions for the exponential tone map unit.
package etm_pkg;

  localparam int ETM_TABLE_ENTRIES = 256;

  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] ONE20 = 64'd1 << 20;

  localparam logic [20:0] LOG2E_Q20 = 21'd1512775;
  localparam logic [15:0] W_RED     = 16'd13938;
  localparam logic [15:0] W_GREEN   = 16'd46868;
  localparam logic [15:0] W_BLUE    = 16'd4730;

  localparam logic [23:0] EXPOSURE_RESET = 24'd65536;
  localparam logic [23:0] MEAN_RESET     = 24'd65536;
  localparam logic [15:0] GAMMA_RESET    = 16'd9011;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EXPOSURE = 2'd0;
  localparam logic [1:0] CFG_MEAN     = 2'd1;
  localparam logic [1:0] CFG_GAMMA    = 2'd2;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] val;
    res  = '0;
    bitv = 64'd1 << 62;
    val  = v;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val = val - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^-t for t in Q.20 (t up to 1.0), result Q.30.
  function automatic logic [30:0] exp_entry(logic [63:0] t);
    logic [63:0] roots [21];
    logic [63:0] v;
    roots[0] = ONE30 >> 1;
    for (int j = 1; j <= 20; j++) roots[j] = isqrt64(roots[j-1] << 30);
    v = ONE30;
    if (t >= ONE20) begin
      v = ONE30 >> 1;
    end else begin
      for (int j = 1; j <= 20; j++)
        if (t[20-j]) v = (v * roots[j] + (ONE30 >> 1)) >> 30;
    end
    return v[30:0];
  endfunction

  // log2 of m in Q.30 (m in [1,2]), result Q.20, by repeated squaring.
  function automatic logic [20:0] log_entry(logic [63:0] m);
    logic [63:0] mv;
    logic [63:0] r;
    mv = m;
    r  = '0;
    if (mv >= 2 * ONE30) return ONE20[20:0];
    for (int j = 0; j < 20; j++) begin
      mv = (mv * mv) >> 30;
      r  = r << 1;
      if (mv >= 2 * ONE30) begin
        mv = mv >> 1;
        r  = r | 64'd1;
      end
    end
    return r[20:0];
  endfunction

endpackage

### hdl/etm_div.sv
// Fully pipelined restoring divider, one quotient bit per stage, with a side tag.
module etm_div #(
  parameter int DW = 48,
  parameter int VW = 32,
  parameter int QW = 21,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [TW-1:0] tag_out
);

  // The caller guarantees dividend >> QW is below the divisor whenever the
  // quotient is used, so the upper part starts as the partial remainder.
  logic [DW-1:0] hi;
  assign hi = dividend >> QW;

  logic          vld  [1:QW];
  logic [VW-1:0] rem  [1:QW];
  logic [QW-1:0] lo   [1:QW];
  logic [VW-1:0] dv   [1:QW];
  logic [TW-1:0] tg   [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic          v_in;
    logic [VW-1:0] r_in;
    logic [QW-1:0] l_in;
    logic [VW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [VW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = hi[VW-1:0];
      assign l_in = dividend[QW-1:0];
      assign d_in = divisor;
      assign t_in = tag_in;
    end else begin : g_next
      assign v_in = vld[s];
      assign r_in = rem[s];
      assign l_in = lo[s];
      assign d_in = dv[s];
      assign t_in = tg[s];
    end

    assign trial = {r_in, l_in[QW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? VW'(trial - {1'b0, d_in}) : trial[VW-1:0];
        lo[s+1]  <= {l_in[QW-2:0], ge};
        dv[s+1]  <= d_in;
        tg[s+1]  <= t_in;
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = lo[QW];
  assign tag_out   = tg[QW];

endmodule

### hdl/exponential_tonemap_pixel_unit.sv
// One pixel per clock sustained while the output is not stalled.
// The unrolled dividers (21, 30 and 25 stages) and the table interpolation stages
// set the depth; every stage holds while the output is stalled.
// Reset clears all valid bits and loads exposure 1.0, mean luminance 1.0, gamma 9011.
// Exp and log are linear interpolations in constant tables of FUNC_TABLE_ENTRIES+1 entries.
module exponential_tonemap_pixel_unit #(
  parameter int FUNC_TABLE_ENTRIES = etm_pkg::ETM_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] red_in,
  input  logic [23:0] green_in,
  input  logic [23:0] blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wr_data
);
  import etm_pkg::*;

  localparam int NW = $clog2(FUNC_TABLE_ENTRIES + 1);
  localparam logic [NW-1:0] NV = NW'(FUNC_TABLE_ENTRIES);

  typedef struct packed {
    logic zero;    // luminance is zero
    logic sat_v;   // rescaled colour at or above one
    logic zero_v;  // rescaled colour is zero
    logic sat_h;   // gamma exponent shift too large
  } etm_flags_t;

  // Constant tables.
  logic [30:0] exp_tab [FUNC_TABLE_ENTRIES+1];
  logic [20:0] log_tab [FUNC_TABLE_ENTRIES+1];

  for (genvar gi = 0; gi <= FUNC_TABLE_ENTRIES; gi++) begin : g_tab
    localparam logic [63:0] TV = (64'(gi) << 20) / FUNC_TABLE_ENTRIES;
    localparam logic [63:0] LM = ONE30 + ((64'(gi) << 30) / FUNC_TABLE_ENTRIES);
    assign exp_tab[gi] = exp_entry(TV);
    assign log_tab[gi] = log_entry(LM);
  end

  // Configuration registers.
  logic [23:0] exposure_scale;
  logic [23:0] mean_luminance;
  logic [15:0] gamma_value;
  logic [31:0] mean_s;
  logic [15:0] gv;
  logic [47:0] mean_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_scale <= EXPOSURE_RESET;
      mean_luminance <= MEAN_RESET;
      gamma_value    <= GAMMA_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXPOSURE: exposure_scale <= cfg_wr_data;
        CFG_MEAN:     mean_luminance <= cfg_wr_data;
        CFG_GAMMA:    gamma_value    <= cfg_wr_data[15:0];
        default:      ;
      endcase
    end
  end

  assign mean_prod = 48'(mean_luminance) * 48'(exposure_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_s <= 32'd65536;
      gv     <= GAMMA_RESET;
    end else begin
      mean_s <= mean_prod[47:16];
      gv     <= (gamma_value == '0) ? 16'd1 : gamma_value;
    end
  end

  // Whole pipeline advances together unless a finished pixel is held.
  logic en;
  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  logic va, vb, vc, vd, ve, vf, vg, vh, vi;
  logic vx;
  logic vj, vk1, vk2, vl, vm, vn, vo, vp, vq, vr;
  logic vdv [3];
  logic vdh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh, vi} <= '0;
      {vj, vk1, vk2, vl, vm, vn, vo, vp, vq, vr, out_valid} <= '0;
    end else if (en) begin
      va  <= in_valid;
      vb  <= va;
      vc  <= vb;
      vd  <= vx;
      ve  <= vd;
      vf  <= ve;
      vg  <= vf;
      vh  <= vg;
      vi  <= vh;
      vj  <= vdv[0] & vdv[1] & vdv[2];
      vk1 <= vj;
      vk2 <= vk1;
      vl  <= vk2;
      vm  <= vl;
      vn  <= vm;
      vo  <= vdh[0] & vdh[1] & vdh[2];
      vp  <= vo;
      vq  <= vp;
      vr  <= vq;
      out_valid <= vr;
    end
  end

  // Exposure scaling, luminance.
  logic [47:0] pa [3];
  logic [31:0] c_a [3];
  logic [47:0] w_b [3];
  logic [31:0] c_b [3];
  logic [31:0] c_c [3];
  logic [31:0] lum_c;
  logic [47:0] lum_sum;

  assign pa[0]   = 48'(red_in)   * 48'(exposure_scale);
  assign pa[1]   = 48'(green_in) * 48'(exposure_scale);
  assign pa[2]   = 48'(blue_in)  * 48'(exposure_scale);
  assign lum_sum = w_b[0] + w_b[1] + w_b[2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_a[i] <= pa[i][47:16];
      w_b[0] <= 48'(c_a[0]) * 48'(W_RED);
      w_b[1] <= 48'(c_a[1]) * 48'(W_GREEN);
      w_b[2] <= 48'(c_a[2]) * 48'(W_BLUE);
      c_b    <= c_a;
      c_c    <= c_b;
      lum_c  <= lum_sum[47:16];
    end
  end

  // Ratio of luminance to the scaled mean; saturates when the ratio reaches 32.
  localparam int XTW = 32 * 4 + 1;
  logic           sat_c;
  logic [XTW-1:0] xtag_in, xtag_out;
  logic [20:0]    xq;

  assign sat_c   = {5'b0, lum_c} >= {mean_s, 5'b0};
  assign xtag_in = {c_c[0], c_c[1], c_c[2], lum_c, sat_c};

  etm_div #(.DW(48), .VW(32), .QW(21), .TW(XTW)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc),
    .dividend  ({lum_c, 16'b0}),
    .divisor   (mean_s),
    .tag_in    (xtag_in),
    .out_valid (vx),
    .quotient  (xq),
    .tag_out   (xtag_out)
  );

  logic [31:0] c_d [3], c_e [3], c_f [3], c_g [3], c_h [3];
  logic [31:0] lum_d, lum_e, lum_f, lum_g, lum_h;
  logic        sat_d, sat_e, sat_f, sat_g;
  logic [25:0] y_d;
  logic [41:0] y_prod;
  logic [5:0]  k_e, k_f, k_g;
  logic [NW-1:0] idx_e, idx1_e;
  logic [19:0]   rem_e, rem_f;
  logic [19+NW:0] p_e;
  logic [30:0] a_f, a_g;
  logic [24:0] d_f;
  logic [44:0] p_g;
  logic [30:0] e_lin, e_sh;
  logic [30:0] lout_h;
  logic        zero_h;

  assign y_prod = 42'(xq) * 42'(LOG2E_Q20);
  assign p_e    = (20 + NW)'(y_d[19:0]) * (20 + NW)'(NV);
  assign idx1_e = NW'(idx_e + 1'b1);
  assign e_lin  = a_g - {6'b0, p_g[44:20]};
  assign e_sh   = (k_g >= 6'd31) ? '0 : (e_lin >> k_g);

  always_ff @(posedge clk) begin
    if (en) begin
      c_d[0] <= xtag_out[128:97];
      c_d[1] <= xtag_out[96:65];
      c_d[2] <= xtag_out[64:33];
      lum_d  <= xtag_out[32:1];
      sat_d  <= xtag_out[0];
      y_d    <= y_prod[41:16];

      c_e   <= c_d;
      lum_e <= lum_d;
      sat_e <= sat_d;
      k_e   <= y_d[25:20];
      idx_e <= p_e[19+NW:20];
      rem_e <= p_e[19:0];

      c_f   <= c_e;
      lum_f <= lum_e;
      sat_f <= sat_e;
      k_f   <= k_e;
      a_f   <= exp_tab[idx_e];
      d_f   <= 25'(exp_tab[idx_e] - exp_tab[idx1_e]);
      rem_f <= rem_e;

      c_g   <= c_f;
      lum_g <= lum_f;
      sat_g <= sat_f;
      k_g   <= k_f;
      a_g   <= a_f;
      p_g   <= 45'(d_f) * 45'(rem_f);

      c_h    <= c_g;
      lum_h  <= lum_g;
      zero_h <= (lum_g == '0);
      lout_h <= sat_g ? ONE30[30:0] : (ONE30[30:0] - e_sh);
    end
  end

  // Per-channel colour rescale, gamma and output quantization.
  logic [15:0] res_s [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [62:0] p_i;
    logic [31:0] lum_i;
    logic        zero_i;
    logic        satv_i;
    logic [1:0]  vtag_out;
    logic [29:0] vq;

    always_ff @(posedge clk) begin
      if (en) begin
        p_i    <= 63'(c_h[ch]) * 63'(lout_h);
        lum_i  <= lum_h;
        zero_i <= zero_h;
      end
    end

    assign satv_i = p_i[62:30] >= {1'b0, lum_i};

    etm_div #(.DW(63), .VW(32), .QW(30), .TW(2)) u_div_v (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vi),
      .dividend  (p_i),
      .divisor   (lum_i),
      .tag_in    ({zero_i, satv_i}),
      .out_valid (vdv[ch]),
      .quotient  (vq),
      .tag_out   (vtag_out)
    );

    // Normalize and take log2 of the rescaled colour.
    logic [4:0]  msb;
    logic [29:0] v_j;
    logic [4:0]  n_j, n_k1, n_k2, n_l, n_m;
    etm_flags_t  f_j, f_k1, f_k2, f_l, f_m, f_n;
    logic [30:0] m_sh;
    logic [29:0] frac_k1;
    logic [29+NW:0] p_k;
    logic [NW-1:0]  idx_k2, idx1_k2;
    logic [29:0] rem_k2, rem_l;
    logic [20:0] lo_l, lo_m;
    logic [15:0] d_l;
    logic [45:0] p_m;
    logic [20:0] lf;
    logic [24:0] g_n;

    // The shift count is taken from the quotient so it lines up with v_j.
    always_comb begin
      msb = '0;
      for (int b = 0; b < 30; b++)
        if (vq[b]) msb = 5'(b);
    end

    assign m_sh    = 31'(v_j) << n_j;
    assign p_k     = (30 + NW)'(frac_k1) * (30 + NW)'(NV);
    assign idx1_k2 = NW'(idx_k2 + 1'b1);
    assign lf      = lo_m + 21'(p_m[45:30]);

    always_ff @(posedge clk) begin
      if (en) begin
        v_j          <= vq;
        f_j.zero     <= vtag_out[1];
        f_j.sat_v    <= vtag_out[0];
        f_j.zero_v   <= (vq == '0);
        f_j.sat_h    <= 1'b0;
        n_j          <= 5'd30 - msb;

        frac_k1 <= m_sh[29:0];
        n_k1    <= n_j;
        f_k1    <= f_j;

        idx_k2 <= p_k[29+NW:30];
        rem_k2 <= p_k[29:0];
        n_k2   <= n_k1;
        f_k2   <= f_k1;

        lo_l  <= log_tab[idx_k2];
        d_l   <= 16'(log_tab[idx1_k2] - log_tab[idx_k2]);
        rem_l <= rem_k2;
        n_l   <= n_k2;
        f_l   <= f_k2;

        p_m  <= 46'(d_l) * 46'(rem_l);
        lo_m <= lo_l;
        n_m  <= n_l;
        f_m  <= f_l;

        g_n <= {n_m, 20'b0} - 25'(lf);
        f_n <= f_m;
      end
    end

    // Divide the log by gamma; saturation means the power is far below one LSB.
    etm_flags_t htag_in, htag_out;
    logic [24:0] hq;

    always_comb begin
      htag_in       = f_n;
      htag_in.sat_h = {4'b0, g_n} >= {gv, 13'b0};
    end

    etm_div #(.DW(37), .VW(16), .QW(25), .TW($bits(etm_flags_t))) u_div_h (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vn),
      .dividend  ({g_n, 12'b0}),
      .divisor   (gv),
      .tag_in    (htag_in),
      .out_valid (vdh[ch]),
      .quotient  (hq),
      .tag_out   (htag_out)
    );

    // 2^-h and quantization to Q0.16.
    logic [19+NW:0] p_o;
    logic [NW-1:0]  idx_o, idx1_o;
    logic [19:0]    rem_o, rem_p;
    logic [4:0]     k_o, k_p, k_q;
    etm_flags_t     f_o, f_p, f_q, f_r;
    logic [30:0]    a_p, a_q;
    logic [24:0]    d_p;
    logic [44:0]    p_q;
    logic [30:0]    r_lin;
    logic [30:0]    v_r;
    logic [46:0]    o_full;

    assign p_o    = (20 + NW)'(hq[19:0]) * (20 + NW)'(NV);
    assign idx1_o = NW'(idx_o + 1'b1);
    assign r_lin  = a_q - {6'b0, p_q[44:20]};
    assign o_full = 47'(v_r) * 47'(16'hFFFF) + 47'(ONE30 >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        k_o   <= hq[24:20];
        idx_o <= p_o[19+NW:20];
        rem_o <= p_o[19:0];
        f_o   <= htag_out;

        a_p   <= exp_tab[idx_o];
        d_p   <= 25'(exp_tab[idx_o] - exp_tab[idx1_o]);
        rem_p <= rem_o;
        k_p   <= k_o;
        f_p   <= f_o;

        p_q <= 45'(d_p) * 45'(rem_p);
        a_q <= a_p;
        k_q <= k_p;
        f_q <= f_p;

        v_r <= (k_q == 5'd31) ? '0 : (r_lin >> k_q);
        f_r <= f_q;

        priority if (f_r.zero) begin
          res_s[ch] <= '0;
        end else if (f_r.sat_v) begin
          res_s[ch] <= 16'hFFFF;
        end else if (f_r.zero_v || f_r.sat_h) begin
          res_s[ch] <= '0;
        end else if (o_full[46:30] > 17'h0FFFF) begin
          res_s[ch] <= 16'hFFFF;
        end else begin
          res_s[ch] <= o_full[45:30];
        end
      end
    end
  end

  assign red_out   = res_s[0];
  assign green_out = res_s[1];
  assign blue_out  = res_s[2];

endmodule

### tb/etm_checker.sv
// Checker for the tone map unit: watches both channels, predicts each pixel and compares.
`timescale 1ns / 100ps
module etm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [23:0] red_in,
  input  logic [23:0] green_in,
  input  logic [23:0] blue_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] red_out,
  input  logic [15:0] green_out,
  input  logic [15:0] blue_out,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wr_data,
  output int          pending,
  output int          mismatches
);
  import etm_pkg::*;

  localparam int N = ETM_TABLE_ENTRIES;
  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [63:0] Q20 = 64'd1 << 20;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } display_pixel_t;

  display_pixel_t expected_pixels[$];
  logic [63:0] exp_tab [N+1];
  logic [63:0] log_tab [N+1];
  logic [23:0] exposure;
  logic [23:0] mean_lum;
  logic [15:0] gamma_reg;

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] root, probe, rest;
    root = 0;
    rest = a;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  initial begin
    logic [63:0] roots [21];
    logic [63:0] t, acc, m, r;
    roots[0] = Q30 >> 1;
    for (int j = 1; j <= 20; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int i = 0; i <= N; i++) begin
      t = (64'(i) << 20) / N;
      acc = Q30;
      if (t >= Q20) acc = Q30 >> 1;
      else
        for (int j = 1; j <= 20; j++)
          if (t[20-j]) acc = (acc * roots[j] + (Q30 >> 1)) >> 30;
      exp_tab[i] = acc;
      if (i >= N) begin
        log_tab[i] = Q20;
      end else begin
        m = Q30 + ((64'(i) << 30) / N);
        r = 0;
        for (int j = 0; j < 20; j++) begin
          m = (m * m) >> 30;
          r = r << 1;
          if (m >= 2 * Q30) begin
            m = m >> 1;
            r = r | 64'd1;
          end
        end
        log_tab[i] = r;
      end
    end
  end

  // 2^-y with y in Q.20, result in Q.30.
  function automatic logic [63:0] pow2_neg(logic [63:0] y);
    logic [63:0] whole, p, idx, frac, a, b, v;
    whole = y >> 20;
    if (whole >= 31) return 0;
    p = (y & (Q20 - 1)) * N;
    idx = p >> 20;
    frac = p & (Q20 - 1);
    if (idx >= N) begin
      idx = N - 1;
      frac = Q20 - 1;
    end
    a = exp_tab[idx];
    b = exp_tab[idx+1];
    v = a - (((a - b) * frac) >> 20);
    return v >> whole;
  endfunction

  function automatic logic [15:0] gamma_channel(logic [63:0] c, logic [63:0] lout,
                                                logic [63:0] lum, logic [63:0] gv);
    logic [63:0] v, m, n, p, idx, frac, lg, g, h;
    v = (c * lout) / lum;
    if (v >= Q30) return 16'hFFFF;
    if (v == 0) return 16'h0000;
    m = v;
    n = 0;
    while (m < Q30) begin
      m = m << 1;
      n++;
    end
    p = (m - Q30) * N;
    idx = p >> 30;
    frac = p & (Q30 - 1);
    if (idx >= N) begin
      idx = N - 1;
      frac = Q30 - 1;
    end
    lg = log_tab[idx] + (((log_tab[idx+1] - log_tab[idx]) * frac) >> 30);
    g = n * Q20 - lg;
    h = (g << 12) / gv;
    v = pow2_neg(h);
    v = (v * 65535 + (Q30 >> 1)) >> 30;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic display_pixel_t tonemap(logic [23:0] r, logic [23:0] g, logic [23:0] b);
    display_pixel_t px;
    logic [63:0] cr, cg, cb, lum, scaled_mean, lout, x, gv;
    cr = (64'(r) * exposure) >> 16;
    cg = (64'(g) * exposure) >> 16;
    cb = (64'(b) * exposure) >> 16;
    lum = (64'(W_RED) * cr + 64'(W_GREEN) * cg + 64'(W_BLUE) * cb) >> 16;
    if (lum == 0) return '0;
    scaled_mean = (64'(mean_lum) * exposure) >> 16;
    if (scaled_mean == 0) begin
      lout = Q30;
    end else begin
      x = (lum << 16) / scaled_mean;
      if (x >= (64'd32 << 16)) lout = Q30;
      else lout = Q30 - pow2_neg((x * 64'(LOG2E_Q20)) >> 16);
    end
    gv = (gamma_reg == 0) ? 64'd1 : 64'(gamma_reg);
    px.red   = gamma_channel(cr, lout, lum, gv);
    px.green = gamma_channel(cg, lout, lum, gv);
    px.blue  = gamma_channel(cb, lout, lum, gv);
    return px;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    display_pixel_t want;
    if (rst) begin
      exposure <= EXPOSURE_RESET;
      mean_lum <= MEAN_RESET;
      gamma_reg <= GAMMA_RESET;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (in_valid && !in_stall) expected_pixels.push_back(tonemap(red_in, green_in, blue_in));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel %0d %0d %0d", red_out, green_out, blue_out);
        end else begin
          want = expected_pixels.pop_front();
          if (want.red !== red_out || want.green !== green_out || want.blue !== blue_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       want.red, want.green, want.blue, red_out, green_out, blue_out);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_EXPOSURE: exposure <= cfg_wr_data;
          CFG_MEAN:     mean_lum <= cfg_wr_data;
          CFG_GAMMA:    gamma_reg <= cfg_wr_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/tb_exponential_tonemap_pixel_unit.sv
// Testbench top for the tone map unit: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module tb_exponential_tonemap_pixel_unit;
  import etm_pkg::*;

  localparam int DRAIN_CYCLES = 110;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [23:0] red_in = 0, green_in = 0, blue_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] red_out, green_out, blue_out;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = CFG_EXPOSURE;
  logic [23:0] cfg_wr_data = 0;
  int pending, mismatches;
  bit steady = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  exponential_tonemap_pixel_unit DUT (.*);

  etm_checker u_checker (.*);

  // Receiver: after each transfer, stall for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (out_stall) begin
      if (stall_left == 0) out_stall <= 0;
      else stall_left <= stall_left - 1;
    end else if (out_valid) begin
      int n;
      n = steady ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1;
        stall_left <= n - 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_config(logic [23:0] e, logic [23:0] m, logic [15:0] g);
    drain();
    write_reg(CFG_EXPOSURE, e);
    write_reg(CFG_MEAN, m);
    write_reg(CFG_GAMMA, {8'd0, g});
  endtask

  function automatic logic [23:0] pick_component(int mode);
    case (mode)
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 24'h3FFFF));
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom_range(0, 24'h1FFFFF));
    endcase
  endfunction

  task automatic random_pixels(int count);
    logic [23:0] r, g, b;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      r = pick_component(mode);
      g = pick_component(mode);
      b = pick_component(mode);
      case ($urandom_range(0, 7))
        0: r = 0;
        1: g = 0;
        2: b = 0;
        3: begin
          g = r;
          b = r;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic directed_pixels;
    send_pixel(0, 0, 0);
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'h010000, 24'h010000, 24'h010000);
    send_pixel(24'hFFFFFF, 0, 0);
    send_pixel(0, 24'hFFFFFF, 0);
    send_pixel(0, 0, 24'hFFFFFF);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 0);
    send_pixel(1, 1, 1);
    send_pixel(24'h000004, 24'h000002, 24'h000010);
    send_pixel(24'h200000, 24'h200000, 24'h200000);
    send_pixel(24'h008000, 24'h004000, 24'h000100);
    send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
    send_pixel(24'h000100, 24'h000001, 24'hFFFFFF);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Reset settings first, then the extremes and a few random settings.
    directed_pixels();
    random_pixels(80);
    set_config(24'h010000, 24'h010000, 16'd9011);
    steady = 1;
    random_pixels(100);
    steady = 0;
    set_config(0, 24'h010000, 16'd9011);
    directed_pixels();
    set_config(24'h010000, 0, 16'd9011);
    directed_pixels();
    random_pixels(50);
    set_config(24'hFFFFFF, 24'hFFFFFF, 16'd40960);
    directed_pixels();
    random_pixels(80);
    set_config(1, 1, 16'd1);
    directed_pixels();
    random_pixels(50);
    set_config(24'h010000, 24'h001000, 16'd0);
    random_pixels(60);
    set_config(24'h008000, 24'h100000, 16'd4096);
    random_pixels(80);
    for (int k = 0; k < 4; k++) begin
      set_config(24'($urandom()), 24'($urandom_range(0, 24'h3FFFFF)),
                 16'($urandom_range(1, 40960)));
      steady = (k == 2);
      random_pixels(70);
    end
    steady = 0;
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
